// ----- design/adc_avg_pkg.sv -----
// Shared constants, types and command/status structs for the ADC averager.
`timescale 1ns / 1ps

package adc_avg_pkg;

    localparam int SAMPLES_PER_BLOCK = 16;
    localparam int ADC_BITS          = 12;
    localparam int NUM_CHANNELS      = 4;

    // Field widths
    localparam int CH_W        = 2;
    localparam int SMP_W       = 12;
    localparam int MEAN_W      = 12;
    localparam int VAL_W       = 21;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - MEAN_W - VAL_W - 2;

    localparam int CH_SLOTS = 1 << CH_W;
    localparam logic [CH_W-1:0] CUR_CHANNEL = CH_W'(1);

    // Configuration widths
    localparam int EN_W    = 4;
    localparam int MVQ_W   = 16;
    localparam int MV_W    = 13;
    localparam int GAIN_W  = 24;
    localparam int BAND_W  = 8;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Accumulation
    localparam int SUM_W = ADC_BITS + $clog2(SAMPLES_PER_BLOCK + 1);
    localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK + 1);

    // Mean = (sum * RCP) >> RCP_SH, exact for every sum below 2^SUM_W
    localparam int RCP_SH = SUM_W + $clog2(SAMPLES_PER_BLOCK);
    localparam int RCP_W  = RCP_SH + 1;
    localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH)
        + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK));

    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

    // Scaling
    localparam int MV_FRAC   = 8;
    localparam int GAIN_FRAC = 16;
    localparam int X_W       = ADC_BITS + MV_W;
    localparam int QUO_W     = MV_W;
    localparam int MAG_W     = MV_W;
    localparam int D_W       = MV_W + 1;
    localparam int DIFF_W    = ADC_BITS + 2;
    localparam int OUT_LIMIT = 1000000;

    // Shared multiplier
    localparam int OPA_W  = (SUM_W > MAG_W) ? SUM_W : MAG_W;
    localparam int OPB_W  = (RCP_W > GAIN_W) ? RCP_W : GAIN_W;
    localparam int PROD_W = OPA_W + OPB_W;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_MVQ    = 3'd1,
        REG_VREF   = 3'd2,
        REG_OFFSET = 3'd3,
        REG_GAIN   = 3'd4,
        REG_BAND   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [EN_W-1:0]   enable_mask;
        logic [MVQ_W-1:0]  mv_per_point_q8;
        logic [MV_W-1:0]   cur_vref_mv;
        logic [MV_W-1:0]   cur_offset_mv;
        logic [GAIN_W-1:0] ma_per_mv_q16;
        logic [BAND_W-1:0] hold_band;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic accum;
        logic mul_mean;
        logic mean_upd;
        logic mul_volt;
        logic mul_cmv;
        logic div_load;
        logic div_step;
        logic offs;
        logic mul_gain;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic block_end;
        logic is_cur;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/adc_average_deadband_scaler.sv -----
// Top level: APB register file, controller and datapath of the ADC block averager.
//
// Input stream: one transfer per ADC sample, channel tag in s_axis_tuser, sample in
// s_axis_tdata. Each enabled channel sums a block of samples; the block's mean is
// compared with the channel's held mean and replaced only when it leaves the hold
// band, then scaled to mV (voltage channels) or mA (current channel) and clipped.
// Output stream: one transfer per completed block; m_axis_tuser carries the channel.
// A sample that does not end a block is accepted, then the per-channel accumulator is
// updated. A block end on a voltage channel passes through the mean, the hold-band update
// and the voltage scaling before its result is loaded; the current channel adds the
// iterative division by the ADC full scale and the offset step, and uses the shared
// multiplier three times in sequence. The next sample is taken after that.
// The result sits in an output register, so a stalled receiver holds up the block
// only when a second result is ready before the first has been taken.
// Reset clears the accumulators and held means and loads register defaults; the
// block accepts samples in the first cycle after reset. APB registers are to be written
// only while idle; the user must ensure it, the block does not enforce it. pready is always high.
`timescale 1ns / 1ps

module adc_average_deadband_scaler
    import adc_avg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    // Sample stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [11:0] sample
    input  logic [CH_W-1:0]        s_axis_tuser,  // [1:0] channel
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [11:0] mean_points, [32:12] scaled_value,
                                                  // [33] held, [34] saturated
    output logic [CH_W-1:0]        m_axis_tuser   // [1:0] out_channel
);

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_sts  sts;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_mask     <= EN_W'(15);
            r_cfg.mv_per_point_q8 <= MVQ_W'(2048);
            r_cfg.cur_vref_mv     <= MV_W'(3300);
            r_cfg.cur_offset_mv   <= MV_W'(1650);
            r_cfg.ma_per_mv_q16   <= GAIN_W'(1638400);
            r_cfg.hold_band       <= BAND_W'(2);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE: r_cfg.enable_mask     <= pwdata[EN_W-1:0];
                REG_MVQ:    r_cfg.mv_per_point_q8 <= pwdata[MVQ_W-1:0];
                REG_VREF:   r_cfg.cur_vref_mv     <= pwdata[MV_W-1:0];
                REG_OFFSET: r_cfg.cur_offset_mv   <= pwdata[MV_W-1:0];
                REG_GAIN:   r_cfg.ma_per_mv_q16   <= pwdata[GAIN_W-1:0];
                REG_BAND:   r_cfg.hold_band       <= pwdata[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENABLE: prdata = PDATA_W'(r_cfg.enable_mask);
            REG_MVQ:    prdata = PDATA_W'(r_cfg.mv_per_point_q8);
            REG_VREF:   prdata = PDATA_W'(r_cfg.cur_vref_mv);
            REG_OFFSET: prdata = PDATA_W'(r_cfg.cur_offset_mv);
            REG_GAIN:   prdata = PDATA_W'(r_cfg.ma_per_mv_q16);
            REG_BAND:   prdata = PDATA_W'(r_cfg.hold_band);
            default:    prdata = '0;
        endcase
    end

    adc_avg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    adc_avg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_channel   (s_axis_tuser),
        .i_sample    (s_axis_tdata[SMP_W-1:0]),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_channel (m_axis_tuser),
        .o_m_data    (m_axis_tdata)
    );

endmodule

// ----- design/adc_avg_dp.sv -----
// Datapath: per-channel accumulators, hold band, shared multiplier, divider, output register.
`timescale 1ns / 1ps

module adc_avg_dp
    import adc_avg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [CH_W-1:0]        i_channel,
    input  logic [SMP_W-1:0]       i_sample,
    input  logic                   i_m_ready,
    output logic                   o_m_valid,
    output logic [CH_W-1:0]        o_m_channel,
    output logic [OUT_TDATA_W-1:0] o_m_data
);

    logic [SUM_W-1:0]    r_sum  [CH_SLOTS];
    logic [CNT_W-1:0]    r_cnt  [CH_SLOTS];
    logic [ADC_BITS-1:0] r_held [CH_SLOTS];

    logic [CH_W-1:0]     r_ch;
    logic [ADC_BITS-1:0] r_smp;
    logic [SUM_W-1:0]    r_acc;
    logic [ADC_BITS-1:0] r_mean;
    logic                r_hold_flag;
    logic [PROD_W-1:0]   r_prod;
    logic [X_W-1:0]      r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;

    logic                r_m_valid;
    logic [CH_W-1:0]     r_m_ch;
    logic [MEAN_W-1:0]   r_m_mean;
    logic [VAL_W-1:0]    r_m_val;
    logic                r_m_held;
    logic                r_m_sat;

    logic [SUM_W-1:0]    sum_new;
    logic [CNT_W-1:0]    cnt_new;
    logic                active;
    logic                block_end;
    logic                is_cur;

    logic [ADC_BITS-1:0] mean_new;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] band_s;
    logic                upd;

    logic [OPA_W-1:0]    mul_a;
    logic [OPB_W-1:0]    mul_b;
    logic                mul_en;

    logic [MV_W-1:0]     div_h;
    logic [ADC_BITS-1:0] div_l;

    logic signed [D_W-1:0] d_val;
    logic [D_W-1:0]      d_neg;

    logic [PROD_W-1:0]   sh_val;
    logic                sat;
    logic [VAL_W-1:0]    mag_v;
    logic [VAL_W-1:0]    val;

    // Block accumulation
    assign sum_new   = r_sum[r_ch] + SUM_W'(r_smp);
    assign cnt_new   = r_cnt[r_ch] + CNT_W'(1);
    assign block_end = (cnt_new == CNT_W'(SAMPLES_PER_BLOCK));
    assign active    = i_cfg.enable_mask[r_ch] && (32'(r_ch) < NUM_CHANNELS);
    assign is_cur    = (r_ch == CUR_CHANNEL);

    // Hold band compare, signed
    assign mean_new = r_prod[RCP_SH +: ADC_BITS];
    assign diff     = $signed(DIFF_W'(mean_new)) - $signed(DIFF_W'(r_held[r_ch]));
    assign band_s   = $signed(DIFF_W'(i_cfg.hold_band));
    assign upd      = (diff > band_s) || (diff < -band_s);

    // Shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        if (i_cmd.mul_mean) begin
            mul_a = OPA_W'(r_acc);
            mul_b = OPB_W'(RCP);
        end else if (i_cmd.mul_volt) begin
            mul_a = OPA_W'(r_mean);
            mul_b = OPB_W'(i_cfg.mv_per_point_q8);
        end else if (i_cmd.mul_cmv) begin
            mul_a = OPA_W'(r_mean);
            mul_b = OPB_W'(i_cfg.cur_vref_mv);
        end else if (i_cmd.mul_gain) begin
            mul_a = OPA_W'(r_mag);
            mul_b = OPB_W'(i_cfg.ma_per_mv_q16);
        end else begin
            mul_en = 1'b0;
        end
    end

    // Division by 2^ADC_BITS-1: fold the high part back into the remainder
    assign div_h = r_rem[X_W-1:ADC_BITS];
    assign div_l = r_rem[ADC_BITS-1:0];

    assign d_val = $signed({1'b0, r_quo}) - $signed({1'b0, i_cfg.cur_offset_mv});
    assign d_neg = -d_val;

    // Final scaling and saturation
    assign sh_val = is_cur ? (r_prod >> GAIN_FRAC) : (r_prod >> MV_FRAC);
    assign sat    = (sh_val > PROD_W'(OUT_LIMIT));
    assign mag_v  = sat ? VAL_W'(OUT_LIMIT) : sh_val[VAL_W-1:0];
    assign val    = r_neg ? -mag_v : mag_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CH_SLOTS; i++) begin
                r_sum[i]  <= '0;
                r_cnt[i]  <= '0;
                r_held[i] <= '0;
            end
        end else begin
            if (i_cmd.accum && active) begin
                r_sum[r_ch] <= block_end ? '0 : sum_new;
                r_cnt[r_ch] <= block_end ? '0 : cnt_new;
            end
            if (i_cmd.mean_upd && upd) begin
                r_held[r_ch] <= mean_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch  <= i_channel;
            r_smp <= ADC_BITS'(i_sample);
        end
        if (i_cmd.accum) begin
            r_acc <= sum_new;
        end
        if (mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (i_cmd.mean_upd) begin
            r_mean      <= upd ? mean_new : r_held[r_ch];
            r_hold_flag <= !upd;
        end
        if (i_cmd.mul_volt) begin
            r_neg <= 1'b0;
        end
        if (i_cmd.div_load) begin
            r_rem <= r_prod[X_W-1:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (div_h != '0) begin
                r_quo <= r_quo + div_h;
                r_rem <= X_W'(div_h) + X_W'(div_l);
            end else begin
                r_quo <= r_quo + QUO_W'(div_l == ADC_MAX);
            end
        end
        if (i_cmd.offs) begin
            r_neg <= d_val[D_W-1];
            r_mag <= d_val[D_W-1] ? MAG_W'(d_neg) : MAG_W'(d_val);
        end
        if (i_cmd.out_load) begin
            r_m_ch   <= r_ch;
            r_m_mean <= MEAN_W'(r_mean);
            r_m_val  <= val;
            r_m_held <= r_hold_flag;
            r_m_sat  <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_sts.active    = active;
    assign o_sts.block_end = block_end;
    assign o_sts.is_cur    = is_cur;
    assign o_sts.div_done  = (div_h == '0);
    assign o_sts.out_free  = !r_m_valid || i_m_ready;

    assign o_m_valid   = r_m_valid;
    assign o_m_channel = r_m_ch;
    assign o_m_data    = {{OUT_PAD_W{1'b0}}, r_m_sat, r_m_held, r_m_val, r_m_mean};

endmodule

// ----- design/adc_avg_ctrl.sv -----
// Controller: sequences accumulation, hold-band update, scaling and result transfer.
`timescale 1ns / 1ps

module adc_avg_ctrl
    import adc_avg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_ACC   = 11'b00000000010,
        S_MUL0  = 11'b00000000100,
        S_MEAN  = 11'b00000001000,
        S_VMUL  = 11'b00000010000,
        S_CMUL  = 11'b00000100000,
        S_DLOAD = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_OFS   = 11'b00100000000,
        S_GAIN  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = (i_sts.active && i_sts.block_end) ? S_MUL0 : S_IDLE;
            end
            S_MUL0: begin
                o_cmd.mul_mean = 1'b1;
                n_state        = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.mean_upd = 1'b1;
                n_state        = i_sts.is_cur ? S_CMUL : S_VMUL;
            end
            S_VMUL: begin
                o_cmd.mul_volt = 1'b1;
                n_state        = S_OUT;
            end
            S_CMUL: begin
                o_cmd.mul_cmv = 1'b1;
                n_state       = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_OFS;
                end
            end
            S_OFS: begin
                o_cmd.offs = 1'b1;
                n_state    = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul_gain = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- tb/tb_adc_average_deadband_scaler.sv -----
// Self-checking testbench for the ADC block averager with hold band and scaling.
`timescale 1ns / 1ps

module tb_adc_average_deadband_scaler;
    import adc_avg_pkg::*;

    localparam int SETTLE   = 20;
    localparam int N_PHASES = 8;
    localparam int PHASE_N  = 115;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [MEAN_W-1:0] mean;
        logic [VAL_W-1:0]  value;
        logic              held;
        logic              sat;
    } t_block_result;

    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_BURSTY
    } t_ready_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [11:0] sample
    logic [CH_W-1:0]        s_axis_tuser;   // [1:0] channel
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [11:0] mean, [32:12] scaled, [33] held, [34] sat
    logic [CH_W-1:0]        m_axis_tuser;   // [1:0] out_channel

    adc_average_deadband_scaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_cfg            shadow_cfg;
    int unsigned     acc_sum [CH_SLOTS];
    int unsigned     acc_cnt [CH_SLOTS];
    int unsigned     hold_mean [CH_SLOTS];
    t_block_result   expected_blocks [$];
    int              centers [CH_SLOTS];
    int              spread = 4;
    int              errors = 0;
    int              n_samples = 0;
    int              n_blocks = 0;
    int              n_held = 0;
    int              n_clipped = 0;
    int              n_settings = 0;
    t_ready_mode     ready_mode = RDY_ALWAYS;
    int              ready_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void reset_shadow();
        shadow_cfg.enable_mask     = EN_W'(15);
        shadow_cfg.mv_per_point_q8 = MVQ_W'(2048);
        shadow_cfg.cur_vref_mv     = MV_W'(3300);
        shadow_cfg.cur_offset_mv   = MV_W'(1650);
        shadow_cfg.ma_per_mv_q16   = GAIN_W'(1638400);
        shadow_cfg.hold_band       = BAND_W'(2);
        for (int c = 0; c < CH_SLOTS; c++) begin
            acc_sum[c]   = 0;
            acc_cnt[c]   = 0;
            hold_mean[c] = 0;
            centers[c]   = $urandom_range(0, int'(ADC_MAX));
        end
    endfunction

    function automatic bit average_and_scale(input logic [CH_W-1:0] ch,
                                             input logic [SMP_W-1:0] smp,
                                             output t_block_result r);
        longint mean, diff, band, mv, d, mag, val;
        bit     keep;
        r = '0;
        if (int'(ch) >= NUM_CHANNELS || !shadow_cfg.enable_mask[ch])
            return 1'b0;
        acc_sum[ch] += smp;
        acc_cnt[ch] += 1;
        if (acc_cnt[ch] < SAMPLES_PER_BLOCK)
            return 1'b0;
        mean = longint'(acc_sum[ch] / SAMPLES_PER_BLOCK);
        acc_sum[ch] = 0;
        acc_cnt[ch] = 0;
        band = longint'(shadow_cfg.hold_band);
        diff = mean - longint'(hold_mean[ch]);
        keep = !(diff > band || diff < -band);
        if (!keep)
            hold_mean[ch] = int'(mean);
        mean = longint'(hold_mean[ch]);
        if (ch == CUR_CHANNEL) begin
            mv  = (mean * longint'(shadow_cfg.cur_vref_mv)) / longint'(ADC_MAX);
            d   = mv - longint'(shadow_cfg.cur_offset_mv);
            mag = ((d < 0) ? -d : d) * longint'(shadow_cfg.ma_per_mv_q16);
            val = (d < 0) ? -(mag >>> GAIN_FRAC) : (mag >>> GAIN_FRAC);
        end else begin
            val = (mean * longint'(shadow_cfg.mv_per_point_q8)) >>> MV_FRAC;
        end
        r.sat = 1'b0;
        if (val > OUT_LIMIT) begin
            val   = OUT_LIMIT;
            r.sat = 1'b1;
        end
        if (val < -OUT_LIMIT) begin
            val   = -OUT_LIMIT;
            r.sat = 1'b1;
        end
        r.ch    = ch;
        r.mean  = MEAN_W'(mean);
        r.value = VAL_W'(val);
        r.held  = keep;
        return 1'b1;
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_ALWAYS: m_axis_tready <= 1'b1;
                RDY_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
                default: begin
                    if (ready_left == 0) begin
                        m_axis_tready <= !m_axis_tready;
                        ready_left    <= m_axis_tready ? $urandom_range(0, 40)
                                                       : $urandom_range(0, 6);
                    end else begin
                        ready_left <= ready_left - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_block_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ch    = m_axis_tuser;
            got.mean  = m_axis_tdata[MEAN_W-1:0];
            got.value = m_axis_tdata[MEAN_W +: VAL_W];
            got.held  = m_axis_tdata[MEAN_W + VAL_W];
            got.sat   = m_axis_tdata[MEAN_W + VAL_W + 1];
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual ch %0d mean %0d",
                         $time, got.ch, got.mean);
                errors++;
            end else begin
                want = expected_blocks.pop_front();
                n_blocks++;
                if (want.held) n_held++;
                if (want.sat) n_clipped++;
                if (got.ch !== want.ch) begin
                    $display("%0t: channel expected %0d actual %0d", $time, want.ch, got.ch);
                    errors++;
                end
                if (got.mean !== want.mean) begin
                    $display("%0t: ch %0d mean expected %0d actual %0d",
                             $time, want.ch, want.mean, got.mean);
                    errors++;
                end
                if (got.value !== want.value) begin
                    $display("%0t: ch %0d scaled expected %0d actual %0d",
                             $time, want.ch, $signed(want.value), $signed(got.value));
                    errors++;
                end
                if (got.held !== want.held) begin
                    $display("%0t: ch %0d held expected %0b actual %0b",
                             $time, want.ch, want.held, got.held);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t: ch %0d saturated expected %0b actual %0b",
                             $time, want.ch, want.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input int index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_ENABLE: shadow_cfg.enable_mask     = value[EN_W-1:0];
            REG_MVQ:    shadow_cfg.mv_per_point_q8 = value[MVQ_W-1:0];
            REG_VREF:   shadow_cfg.cur_vref_mv     = value[MV_W-1:0];
            REG_OFFSET: shadow_cfg.cur_offset_mv   = value[MV_W-1:0];
            REG_GAIN:   shadow_cfg.ma_per_mv_q16   = value[GAIN_W-1:0];
            REG_BAND:   shadow_cfg.hold_band       = value[BAND_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
        t_block_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(smp);
        s_axis_tuser  <= ch;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_samples++;
        if (average_and_scale(ch, smp, r))
            expected_blocks.push_back(r);
    endtask

    task automatic idle(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic int pick_center();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return int'(ADC_MAX);
            default: return $urandom_range(0, int'(ADC_MAX));
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] next_sample(input int ch);
        int v;
        if ($urandom_range(0, 39) == 0)
            centers[ch] = pick_center();
        if ($urandom_range(0, 19) == 0)
            return SMP_W'($urandom_range(0, int'(ADC_MAX)));
        v = centers[ch] + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > int'(ADC_MAX)) v = int'(ADC_MAX);
        return SMP_W'(v);
    endfunction

    function automatic logic [PDATA_W-1:0] pick_reg(input int width, input int legal_max);
        logic [PDATA_W-1:0] full, v;
        full = (PDATA_W'(1) << width) - 1;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = full;
            2:       v = PDATA_W'(legal_max);
            default: v = PDATA_W'($urandom) & full;
        endcase
        if ($urandom_range(0, 3) == 0)
            v = v | (PDATA_W'($urandom) & ~full);
        return v;
    endfunction

    task automatic test_dropped_channel();
        write_reg(REG_ENABLE, 32'hE);
        send_sample(CH_W'(0), ADC_MAX);
    endtask

    // first current block after reset, compared against a held mean of zero;
    // unmapped register writes land mid-block and must leave the scaling alone
    task automatic test_first_block_and_unmapped();
        repeat (8) send_sample(CUR_CHANNEL, ADC_MAX);
        wait_drained(SETTLE);
        write_reg(6, '1);
        write_reg(7, '1);
        repeat (8) send_sample(CUR_CHANNEL, '0);
    endtask

    task automatic test_all_disabled();
        wait_drained(SETTLE);
        write_reg(REG_ENABLE, '0);
        repeat (20) send_sample(CH_W'($urandom_range(0, CH_SLOTS - 1)), SMP_W'($urandom));
    endtask

    task automatic test_random_phase(input int idx, input int n_items);
        int               sent, burst, gap_max;
        bit               paused;
        logic [CH_W-1:0]  ch;
        wait_drained(SETTLE);
        n_settings++;
        case (idx)
            0: begin
                write_reg(REG_ENABLE, 32'hF);
                write_reg(REG_MVQ, '0);
                write_reg(REG_VREF, '0);
                write_reg(REG_OFFSET, '0);
                write_reg(REG_GAIN, '0);
                write_reg(REG_BAND, '0);
            end
            1: begin
                write_reg(REG_ENABLE, 32'hF);
                write_reg(REG_MVQ, 32'hFFFF);
                write_reg(REG_VREF, 32'h1FFF);
                write_reg(REG_OFFSET, 32'h1FFF);
                write_reg(REG_GAIN, 32'hFF_FFFF);
                write_reg(REG_BAND, 32'hFF);
            end
            default: begin
                write_reg(REG_ENABLE, ($urandom_range(0, 1) != 0) ? 32'hF : $urandom_range(1, 15));
                write_reg(REG_MVQ, pick_reg(MVQ_W, 65535));
                write_reg(REG_VREF, pick_reg(MV_W, 5000));
                write_reg(REG_OFFSET, pick_reg(MV_W, 5000));
                write_reg(REG_GAIN, pick_reg(GAIN_W, 16777215));
                write_reg(REG_BAND, ($urandom_range(0, 2) == 0) ? pick_reg(BAND_W, 255)
                                                                : $urandom_range(0, 12));
            end
        endcase
        ready_mode <= t_ready_mode'(idx % 3);
        gap_max = (idx % 4 == 0) ? 0 : $urandom_range(1, 10);
        spread  = $urandom_range(0, 3 * int'(shadow_cfg.hold_band) + 6);
        sent    = 0;
        burst   = 0;
        paused  = 1'b0;
        while (sent < n_items) begin
            if (burst == 0) begin
                idle($urandom_range(0, gap_max));
                burst = $urandom_range(1, 24);
            end
            burst--;
            if (!paused && sent == n_items / 2) begin
                wait_drained(0);
                paused = 1'b1;
            end
            ch = CH_W'($urandom_range(0, CH_SLOTS - 1));
            sent++;
            send_sample(ch, next_sample(int'(ch)));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        reset_shadow();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dropped_channel();
        test_first_block_and_unmapped();
        for (int p = 0; p < N_PHASES; p++) begin
            test_random_phase(p, PHASE_N);
            if (p == 3)
                test_all_disabled();
        end
        wait_drained(SETTLE);

        $display("covered %0d samples over %0d register settings plus directed cases",
                 n_samples, n_settings);
        $display("%0d block results checked, %0d held, %0d clipped",
                 n_blocks, n_held, n_clipped);
        if (errors == 0) begin
            $display("tb_adc_average_deadband_scaler: clean");
        end else begin
            $display("tb_adc_average_deadband_scaler: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_blocks.size());
        $display("tb_adc_average_deadband_scaler: errors");
        $finish;
    end

endmodule

// ----- files.f -----
design/adc_avg_pkg.sv
design/adc_avg_dp.sv
design/adc_avg_ctrl.sv
design/adc_average_deadband_scaler.sv
tb/tb_adc_average_deadband_scaler.sv
